// ----- src/lbmc_pkg.sv -----
`default_nettype none

package lbmc_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int VAL_W = 24;   // every field of both channels
  localparam int SUM_W = 28;   // exact sum of up to nine fields
  localparam int MOM_W = 27;   // exact momentum
  localparam int NDIR  = 9;

  // velocity divider: quotient bits per lane, denominator bits (positive rho)
  localparam int QUO_W = 25;
  localparam int DEN_W = 23;

  // equilibrium scaling: rho * weight numerator and the bracket word
  localparam int A_W    = 28;
  localparam int BR_W   = 64;
  localparam int QL_W   = 29;  // floor(product / 2^F) saturates at or above 2^QL_W
  localparam int EU_W   = 26;

  // rounding divide by 36: add half of 36, drop two bits, multiply by 1/9
  localparam logic [4:0]  EQ_HALF_DEN = 5'd18;
  localparam logic [28:0] RECIP9      = 29'd477218589;
  localparam int          RECIP_SH    = 32;

  // front-to-back queue, depth is a power of two
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  typedef logic signed [VAL_W-1:0] val_t;

  localparam val_t VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam val_t VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef struct packed {
    val_t f_rest;
    val_t f_east;
    val_t f_north;
    val_t f_west;
    val_t f_south;
    val_t f_northeast;
    val_t f_northwest;
    val_t f_southwest;
    val_t f_southeast;
    val_t push_vel_x;
    val_t push_vel_y;
  } lbmc_in_t;

  typedef struct packed {
    val_t eq_rest;
    val_t eq_east;
    val_t eq_north;
    val_t eq_west;
    val_t eq_south;
    val_t eq_northeast;
    val_t eq_northwest;
    val_t eq_southwest;
    val_t eq_southeast;
    val_t density;
    val_t vel_x;
    val_t vel_y;
  } lbmc_out_t;

  // node after classification: density, momentum and forcing
  typedef struct packed {
    val_t                    rho;
    logic signed [MOM_W-1:0] mx;
    logic signed [MOM_W-1:0] my;
    val_t                    push_x;
    val_t                    push_y;
  } lbmc_node_t;

  // node after the divider: density, velocity, forced velocity
  typedef struct packed {
    val_t rho;
    val_t ux;
    val_t uy;
    val_t vx;
    val_t vy;
  } lbmc_vel_t;

  function automatic val_t sat_val(input logic signed [SUM_W-1:0] v);
    val_t r;
    if (v[SUM_W-1:VAL_W-1] == '0 || v[SUM_W-1:VAL_W-1] == '1) begin
      r = v[VAL_W-1:0];
    end else if (v[SUM_W-1]) begin
      r = VAL_MIN;
    end else begin
      r = VAL_MAX;
    end
    return r;
  endfunction

  // lattice directions in order rest, E, N, W, S, NE, NW, SW, SE
  function automatic logic signed [1:0] dir_ex(input int k);
    logic signed [1:0] e;
    case (k)
      1, 5, 8: e = 2'sb01;
      3, 6, 7: e = 2'sb11;
      default: e = 2'sb00;
    endcase
    return e;
  endfunction

  function automatic logic signed [1:0] dir_ey(input int k);
    logic signed [1:0] e;
    case (k)
      2, 5, 6: e = 2'sb01;
      4, 7, 8: e = 2'sb11;
      default: e = 2'sb00;
    endcase
    return e;
  endfunction

  // weight numerator over 36 as a left shift: 16, 4 or 1
  function automatic logic [2:0] dir_wshift(input int k);
    logic [2:0] s;
    case (k)
      0:          s = 3'd4;
      1, 2, 3, 4: s = 3'd2;
      default:    s = 3'd0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- src/lbmc_front.sv -----
`default_nettype none

module lbmc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                node_valid,
  output logic                node_stall,
  input  lbmc_pkg::lbmc_in_t  node_data,
  output logic                push,
  input  logic                full,
  output lbmc_pkg::lbmc_node_t push_data
);
  import lbmc_pkg::*;

  logic                    held;
  logic                    accept;
  logic signed [SUM_W-1:0] sum;
  logic signed [MOM_W-1:0] mx_n;
  logic signed [MOM_W-1:0] my_n;

  assign push       = held && !full;
  assign node_stall = held && full;
  assign accept     = node_valid && !node_stall;

  always_comb begin
    sum = SUM_W'(node_data.f_rest) + SUM_W'(node_data.f_east) + SUM_W'(node_data.f_north)
        + SUM_W'(node_data.f_west) + SUM_W'(node_data.f_south)
        + SUM_W'(node_data.f_northeast) + SUM_W'(node_data.f_northwest)
        + SUM_W'(node_data.f_southwest) + SUM_W'(node_data.f_southeast);
    mx_n = MOM_W'(node_data.f_east) + MOM_W'(node_data.f_northeast)
         + MOM_W'(node_data.f_southeast) - MOM_W'(node_data.f_west)
         - MOM_W'(node_data.f_northwest) - MOM_W'(node_data.f_southwest);
    my_n = MOM_W'(node_data.f_north) + MOM_W'(node_data.f_northeast)
         + MOM_W'(node_data.f_northwest) - MOM_W'(node_data.f_south)
         - MOM_W'(node_data.f_southeast) - MOM_W'(node_data.f_southwest);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (accept) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      push_data.rho    <= sat_val(sum);
      push_data.mx     <= mx_n;
      push_data.my     <= my_n;
      push_data.push_x <= node_data.push_vel_x;
      push_data.push_y <= node_data.push_vel_y;
    end
  end

endmodule

`default_nettype wire

// ----- src/lbmc_queue.sv -----
`default_nettype none

module lbmc_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  lbmc_pkg::lbmc_node_t push_data,
  output logic                 full,
  input  logic                 pop,
  output logic                 empty,
  output lbmc_pkg::lbmc_node_t head
);
  import lbmc_pkg::*;

  lbmc_node_t     slots [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;

  assign full  = count == (QAW+1)'(QDEPTH);
  assign empty = count == '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QAW+1)'(QDEPTH))
    else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

// ----- src/lbmc_vel_div.sv -----
`default_nettype none

module lbmc_vel_div #(
  parameter int FRAC_BITS = lbmc_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_valid,
  input  lbmc_pkg::lbmc_node_t in_data,
  output logic                 out_valid,
  output lbmc_pkg::lbmc_vel_t  out_data
);
  import lbmc_pkg::*;

  localparam int NUM_W = MOM_W + FRAC_BITS;
  localparam int CMP_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;
  localparam int STEPS = QUO_W;

  logic [STEPS:0]   vld;
  logic [DEN_W-1:0] rem_x [STEPS+1];
  logic [DEN_W-1:0] rem_y [STEPS+1];
  logic [QUO_W-1:0] wq_x  [STEPS+1];
  logic [QUO_W-1:0] wq_y  [STEPS+1];
  logic [DEN_W-1:0] den   [STEPS+1];
  logic [STEPS:0]   ovf_x;
  logic [STEPS:0]   ovf_y;
  logic [STEPS:0]   neg_x;
  logic [STEPS:0]   neg_y;
  logic [STEPS:0]   nonpos;
  val_t             rho_p  [STEPS+1];
  val_t             push_x [STEPS+1];
  val_t             push_y [STEPS+1];

  logic [MOM_W-2:0] mag_x;
  logic [MOM_W-2:0] mag_y;
  logic             pos;
  logic [DEN_W-1:0] den0;
  logic [NUM_W-1:0] num_x;
  logic [NUM_W-1:0] num_y;
  val_t             ux_n;
  val_t             uy_n;

  function automatic logic [DEN_W+QUO_W-1:0] div_step(input logic [DEN_W-1:0] rem,
                                                        input logic [QUO_W-1:0] wq,
                                                        input logic [DEN_W-1:0] d);
    logic [DEN_W:0]   t;
    logic             ge;
    logic [DEN_W-1:0] r;
    t  = {rem, wq[QUO_W-1]};
    ge = t >= {1'b0, d};
    r  = ge ? DEN_W'(t - {1'b0, d}) : t[DEN_W-1:0];
    return {r, wq[QUO_W-2:0], ge};
  endfunction

  // quotient magnitude to signed velocity, saturated to the val_t range; zero at non-positive density
  function automatic val_t finish(input logic [QUO_W-1:0] q, input logic ovf,
                                  input logic neg, input logic zero);
    val_t v;
    if (zero) begin
      v = '0;
    end else if (ovf || q[QUO_W-1:VAL_W-1] != '0) begin
      v = neg ? VAL_MIN : VAL_MAX;
    end else if (neg) begin
      v = -{1'b0, q[VAL_W-2:0]};
    end else begin
      v = {1'b0, q[VAL_W-2:0]};
    end
    return v;
  endfunction

  // operands: |m| * 2^F + floor(rho/2), so a plain quotient rounds to nearest
  always_comb begin
    mag_x = in_data.mx[MOM_W-1] ? (MOM_W-1)'(-in_data.mx) : (MOM_W-1)'(in_data.mx);
    mag_y = in_data.my[MOM_W-1] ? (MOM_W-1)'(-in_data.my) : (MOM_W-1)'(in_data.my);
    pos   = !in_data.rho[VAL_W-1] && (in_data.rho != '0);
    den0  = pos ? in_data.rho[DEN_W-1:0] : DEN_W'(1);
    num_x = (NUM_W'(mag_x) << FRAC_BITS) + NUM_W'(den0 >> 1);
    num_y = (NUM_W'(mag_y) << FRAC_BITS) + NUM_W'(den0 >> 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld       <= {vld[STEPS-1:0], in_valid};
      out_valid <= vld[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_x[0]  <= DEN_W'(num_x >> QUO_W);
      rem_y[0]  <= DEN_W'(num_y >> QUO_W);
      wq_x[0]   <= num_x[QUO_W-1:0];
      wq_y[0]   <= num_y[QUO_W-1:0];
      ovf_x[0]  <= CMP_W'(num_x) >= (CMP_W'(den0) << QUO_W);
      ovf_y[0]  <= CMP_W'(num_y) >= (CMP_W'(den0) << QUO_W);
      den[0]    <= den0;
      neg_x[0]  <= in_data.mx[MOM_W-1];
      neg_y[0]  <= in_data.my[MOM_W-1];
      nonpos[0] <= !pos;
      rho_p[0]  <= in_data.rho;
      push_x[0] <= in_data.push_x;
      push_y[0] <= in_data.push_y;
      for (int i = 0; i < STEPS; i++) begin
        {rem_x[i+1], wq_x[i+1]} <= div_step(rem_x[i], wq_x[i], den[i]);
        {rem_y[i+1], wq_y[i+1]} <= div_step(rem_y[i], wq_y[i], den[i]);
        den[i+1]    <= den[i];
        ovf_x[i+1]  <= ovf_x[i];
        ovf_y[i+1]  <= ovf_y[i];
        neg_x[i+1]  <= neg_x[i];
        neg_y[i+1]  <= neg_y[i];
        nonpos[i+1] <= nonpos[i];
        rho_p[i+1]  <= rho_p[i];
        push_x[i+1] <= push_x[i];
        push_y[i+1] <= push_y[i];
      end
    end
  end

  always_comb begin
    ux_n = finish(wq_x[STEPS], ovf_x[STEPS], neg_x[STEPS], nonpos[STEPS]);
    uy_n = finish(wq_y[STEPS], ovf_y[STEPS], neg_y[STEPS], nonpos[STEPS]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.rho <= rho_p[STEPS];
      out_data.ux  <= ux_n;
      out_data.uy  <= uy_n;
      out_data.vx  <= sat_val(SUM_W'(ux_n) + SUM_W'(push_x[STEPS]));
      out_data.vy  <= sat_val(SUM_W'(uy_n) + SUM_W'(push_y[STEPS]));
    end
  end

  a_zero_density: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.rho[VAL_W-1] || out_data.rho == '0)
      |-> out_data.ux == '0 && out_data.uy == '0)
    else $error("nonzero velocity at non-positive density");

endmodule

`default_nettype wire

// ----- src/lbmc_equil.sv -----
`default_nettype none

module lbmc_equil #(
  parameter int FRAC_BITS = lbmc_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_valid,
  input  lbmc_pkg::lbmc_vel_t in_data,
  output logic                out_valid,
  output lbmc_pkg::lbmc_out_t out_data
);
  import lbmc_pkg::*;

  localparam int NST = 7;
  localparam logic signed [BR_W-1:0] ONE_F  = BR_W'(64'sd1 <<< FRAC_BITS);
  localparam logic signed [BR_W-1:0] ONE_2F = BR_W'(64'sd1 <<< (2 * FRAC_BITS + 1));

  typedef struct packed {
    val_t rho;
    val_t ux;
    val_t uy;
  } side_t;

  logic [NST-1:0] vld;
  side_t          side [NST];

  // stage 1: projections and squares of the forced velocity
  logic signed [EU_W-1:0]    eu1 [NDIR];
  logic signed [2*VAL_W-1:0] vxx1;
  logic signed [2*VAL_W-1:0] vyy1;
  // stage 2
  logic signed [EU_W-1:0]    eu2  [NDIR];
  logic signed [2*EU_W-1:0]  esq2 [NDIR];
  logic [2*VAL_W-1:0]        vsq2;
  // stage 3: twice the bracket at 2F fraction bits
  logic signed [BR_W-1:0]    b2_3 [NDIR];
  // stage 4
  logic [NDIR-1:0]           neg4;
  logic [NDIR-1:0]           big4;
  logic [A_W-1:0]            a4  [NDIR];
  logic [QL_W-1:0]           bh4 [NDIR];
  logic [FRAC_BITS-1:0]      bl4 [NDIR];
  // stage 5
  logic [NDIR-1:0]           neg5;
  logic [NDIR-1:0]           big5;
  logic [A_W+QL_W-1:0]       ah5 [NDIR];
  logic [A_W+FRAC_BITS-1:0]  al5 [NDIR];
  // stage 6
  logic [NDIR-1:0]           neg6;
  logic [NDIR-1:0]           sat6;
  logic [A_W-1:0]            y6 [NDIR];
  // stage 7
  logic [NDIR-1:0]           neg7;
  logic [NDIR-1:0]           sat7;
  logic [A_W+QL_W-1:0]       pr7 [NDIR];

  val_t                      eq_n [NDIR];

  function automatic logic signed [EU_W-1:0] proj(input int k, input val_t vx, input val_t vy);
    logic signed [EU_W-1:0] tx;
    logic signed [EU_W-1:0] ty;
    if (dir_ex(k) == 2'sb01) begin
      tx = EU_W'(vx);
    end else if (dir_ex(k) == 2'sb11) begin
      tx = -EU_W'(vx);
    end else begin
      tx = '0;
    end
    if (dir_ey(k) == 2'sb01) begin
      ty = EU_W'(vy);
    end else if (dir_ey(k) == 2'sb11) begin
      ty = -EU_W'(vy);
    end else begin
      ty = '0;
    end
    return tx + ty;
  endfunction

  // 2 + 6 eu + 9 eu^2 - 3 v.v, exact
  function automatic logic signed [BR_W-1:0] bracket(input logic signed [EU_W-1:0] eu,
                                                     input logic signed [2*EU_W-1:0] esq,
                                                     input logic [2*VAL_W-1:0] vsq);
    logic signed [BR_W-1:0] e;
    logic signed [BR_W-1:0] s;
    logic signed [BR_W-1:0] q;
    e = BR_W'(eu);
    s = BR_W'(esq);
    q = $signed(BR_W'(vsq));
    return ONE_2F + (((e <<< 2) + (e <<< 1)) <<< FRAC_BITS) + (s <<< 3) + s
         - ((q <<< 1) + q);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld       <= {vld[NST-2:0], in_valid};
      out_valid <= vld[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    logic [BR_W-1:0]  sh;
    logic [BR_W-1:0]  bm;
    logic [VAL_W-1:0] rmag;
    logic [A_W:0]     qsum;
    logic [QL_W:0]    qr;
    if (adv) begin
      side[0] <= '{rho: in_data.rho, ux: in_data.ux, uy: in_data.uy};
      for (int s = 1; s < NST; s++) begin
        side[s] <= side[s-1];
      end

      vxx1 <= in_data.vx * in_data.vx;
      vyy1 <= in_data.vy * in_data.vy;
      vsq2 <= (2*VAL_W)'(vxx1[2*VAL_W-2:0]) + (2*VAL_W)'(vyy1[2*VAL_W-2:0]);

      rmag = side[2].rho[VAL_W-1] ? VAL_W'(-side[2].rho) : VAL_W'(side[2].rho);

      for (int k = 0; k < NDIR; k++) begin
        eu1[k]  <= proj(k, in_data.vx, in_data.vy);
        eu2[k]  <= eu1[k];
        esq2[k] <= eu1[k] * eu1[k];
        b2_3[k] <= bracket(eu2[k], esq2[k], vsq2);

        // round the bracket to F fraction bits, split at 2^F for two products
        sh = b2_3[k][BR_W-1] ? BR_W'(ONE_F - b2_3[k]) : BR_W'(b2_3[k] + ONE_F);
        bm = sh >> (FRAC_BITS + 1);
        neg4[k] <= b2_3[k][BR_W-1] ^ side[2].rho[VAL_W-1];
        big4[k] <= (bm >> (FRAC_BITS + QL_W)) != '0;
        bh4[k]  <= bm[FRAC_BITS +: QL_W];
        bl4[k]  <= bm[FRAC_BITS-1:0];
        a4[k]   <= A_W'(rmag) << dir_wshift(k);

        ah5[k]  <= A_W'(a4[k]) * (A_W+QL_W)'(bh4[k]);
        al5[k]  <= (A_W+FRAC_BITS)'(a4[k]) * (A_W+FRAC_BITS)'(bl4[k]);
        neg5[k] <= neg4[k];
        big5[k] <= big4[k] && (a4[k] != '0);

        // floor(rho * w * bracket / 2^F); at or above 2^29 the result saturates
        qsum    = (A_W+1)'(al5[k] >> FRAC_BITS);
        neg6[k] <= neg5[k];
        sat6[k] <= big5[k] || ((ah5[k] + (A_W+QL_W)'(qsum)) >> QL_W) != '0;
        qr      = (QL_W+1)'(ah5[k][QL_W-1:0] + (A_W+QL_W)'(qsum)) + (QL_W+1)'(EQ_HALF_DEN);
        y6[k]   <= qr[QL_W:2];

        neg7[k] <= neg6[k];
        sat7[k] <= sat6[k];
        pr7[k]  <= (A_W+QL_W)'(y6[k]) * (A_W+QL_W)'(RECIP9);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NDIR; k++) begin
      if (sat7[k] || pr7[k][A_W+QL_W-1:RECIP_SH+VAL_W-1] != '0) begin
        eq_n[k] = neg7[k] ? VAL_MIN : VAL_MAX;
      end else if (neg7[k]) begin
        eq_n[k] = -{1'b0, pr7[k][RECIP_SH +: VAL_W-1]};
      end else begin
        eq_n[k] = {1'b0, pr7[k][RECIP_SH +: VAL_W-1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.eq_rest      <= eq_n[0];
      out_data.eq_east      <= eq_n[1];
      out_data.eq_north     <= eq_n[2];
      out_data.eq_west      <= eq_n[3];
      out_data.eq_south     <= eq_n[4];
      out_data.eq_northeast <= eq_n[5];
      out_data.eq_northwest <= eq_n[6];
      out_data.eq_southwest <= eq_n[7];
      out_data.eq_southeast <= eq_n[8];
      out_data.density      <= side[NST-1].rho;
      out_data.vel_x        <= side[NST-1].ux;
      out_data.vel_y        <= side[NST-1].uy;
    end
  end

  a_zero_density_eq: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.density == '0 |-> out_data.eq_rest == '0 && out_data.eq_east == '0)
    else $error("nonzero equilibrium at zero density");

endmodule

`default_nettype wire

// ----- src/lbm_d2q9_node_collision.sv -----
`default_nettype none

// D2Q9 lattice Boltzmann collision, one node per transaction.
// Input channel node_*: nine streamed populations and a forcing velocity,
// all signed with FRAC_BITS fraction bits. Output channel result_*: the nine
// equilibrium populations, the density and the node velocity before forcing.
// A transaction moves at a clock edge with valid high and stall low.
// Throughput: one node per cycle, sustained while the output is not stalled.
// The front stage sums density and momentum and pushes into a four-entry
// queue; the back pipeline (25-step restoring divider for the velocity, then
// eight equilibrium stages) pops one node per cycle while it advances.
// When a result is offered and result_stall is high, the whole back pipeline
// holds; with no result offered it keeps advancing. Held long enough, the
// queue fills, and node_stall rises once the queue and the front register
// are full. Reset (rst, synchronous) empties the front register, the queue
// and every pipeline valid bit; no transaction is in flight afterward.
module lbm_d2q9_node_collision #(
  parameter int FRAC_BITS = lbmc_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                node_valid,
  output logic                node_stall,
  input  lbmc_pkg::lbmc_in_t  node_data,
  output logic                result_valid,
  input  logic                result_stall,
  output lbmc_pkg::lbmc_out_t result_data
);
  import lbmc_pkg::*;

  logic       push;
  logic       full;
  logic       pop;
  logic       empty;
  logic       adv;
  logic       vel_valid;
  lbmc_node_t push_data;
  lbmc_node_t head;
  lbmc_vel_t  vel_data;

  // advance the back pipeline unless a finished result is held by the receiver
  assign adv = !result_valid || !result_stall;
  assign pop = adv && !empty;

  lbmc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .node_valid (node_valid),
    .node_stall (node_stall),
    .node_data  (node_data),
    .push       (push),
    .full       (full),
    .push_data  (push_data)
  );

  lbmc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .empty     (empty),
    .head      (head)
  );

  lbmc_vel_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_vel_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (!empty),
    .in_data   (head),
    .out_valid (vel_valid),
    .out_data  (vel_data)
  );

  lbmc_equil #(
    .FRAC_BITS (FRAC_BITS)
  ) u_equil (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (vel_valid),
    .in_data   (vel_data),
    .out_valid (result_valid),
    .out_data  (result_data)
  );

  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst) node_stall |-> full)
    else $error("input stalled while queue has room");

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
  import lbmc_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int LATENCY = 36;

  logic      clk;
  logic      rst;
  logic      node_valid;
  logic      node_stall;
  lbmc_in_t  node_data;
  logic      result_valid;
  logic      result_stall;
  lbmc_out_t result_data;

  lbm_d2q9_node_collision u_top (
    .clk(clk),
    .rst(rst),
    .node_valid(node_valid),
    .node_stall(node_stall),
    .node_data(node_data),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result_data(result_data)
  );

  // Free-running clock, 8 ns period.
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  lbmc_out_t expected_nodes[$];
  int        n_fail;
  int        n_nodes;
  int        n_results;
  bit        quiet_mode;   // when set, no idling on either side

  // Saturate a wide value to the 24-bit signed range.
  function automatic longint clamp24(input longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  function automatic longint mag64(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Compute the collision result for one node: density, velocity, and the
  // nine equilibrium populations, all in Q8.16 with round-half-away.
  function automatic lbmc_out_t collide(input lbmc_in_t n);
    longint f[9];
    longint rho, mx, my, ux, uy, vx, vy, vsq, eu, b2, bm, a, r, eq, qx, qy;
    longint ex[9], ey[9], wn[9];
    bit neg;
    lbmc_out_t o;
    ex = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
    ey = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
    wn = '{16, 4, 4, 4, 4, 1, 1, 1, 1};
    f[0] = n.f_rest;      f[1] = n.f_east;      f[2] = n.f_north;
    f[3] = n.f_west;      f[4] = n.f_south;     f[5] = n.f_northeast;
    f[6] = n.f_northwest; f[7] = n.f_southwest; f[8] = n.f_southeast;
    rho = 0;
    for (int k = 0; k < 9; k++) rho += f[k];
    rho = clamp24(rho);
    mx = f[1] + f[5] + f[8] - f[3] - f[6] - f[7];
    my = f[2] + f[5] + f[6] - f[4] - f[8] - f[7];
    ux = 0;
    uy = 0;
    // Nonpositive density: velocity is forced to zero.
    if (rho > 0) begin
      qx = ((mag64(mx) << FB) + rho / 2) / rho;
      qy = ((mag64(my) << FB) + rho / 2) / rho;
      ux = clamp24((mx < 0) ? -qx : qx);
      uy = clamp24((my < 0) ? -qy : qy);
    end
    vx = clamp24(ux + longint'(n.push_vel_x));
    vy = clamp24(uy + longint'(n.push_vel_y));
    vsq = vx * vx + vy * vy;
    for (int k = 0; k < 9; k++) begin
      eu = ex[k] * vx + ey[k] * vy;
      b2 = (64'sd1 <<< (2 * FB + 1)) + 6 * eu * (64'sd1 <<< FB) + 9 * eu * eu - 3 * vsq;
      bm = (mag64(b2) + (64'sd1 <<< FB)) >>> (FB + 1);
      a = mag64(rho) * wn[k];
      neg = (b2 < 0) != (rho < 0);
      if (a == 0 || bm == 0) begin
        eq = 0;
      end else if (bm > ((64'sd1 <<< 62) - 1) / a) begin
        // product at or above 2^62: saturate with its sign
        eq = neg ? -64'sd8388608 : 64'sd8388607;
      end else begin
        r = (a * bm + ((64'sd36 <<< FB) / 2)) / (64'sd36 <<< FB);
        eq = clamp24(neg ? -r : r);
      end
      case (k)
        0: o.eq_rest = eq[23:0];
        1: o.eq_east = eq[23:0];
        2: o.eq_north = eq[23:0];
        3: o.eq_west = eq[23:0];
        4: o.eq_south = eq[23:0];
        5: o.eq_northeast = eq[23:0];
        6: o.eq_northwest = eq[23:0];
        7: o.eq_southwest = eq[23:0];
        default: o.eq_southeast = eq[23:0];
      endcase
    end
    o.density = rho[23:0];
    o.vel_x = ux[23:0];
    o.vel_y = uy[23:0];
    return o;
  endfunction

  // Compare one field and report a mismatch.
  task automatic check_field(input string name, input val_t exp_v, input val_t act_v);
    if (exp_v !== act_v) begin
      n_fail++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  // Drive the result stall: random bursts, none in quiet mode.
  initial begin
    result_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet_mode && $urandom_range(0, 5) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        result_stall <= 1'b0;
      end else if (!quiet_mode && $urandom_range(0, 3) == 0) begin
        // long stretch with no stall
        repeat ($urandom_range(5, 30)) @(posedge clk);
      end
    end
  end

  // Score each result transaction against the oldest expectation.
  always @(posedge clk) begin
    lbmc_out_t exp_o;
    if (!rst && result_valid && !result_stall) begin
      if (expected_nodes.size() == 0) begin
        n_fail++;
        $display("%0t: unexpected result, actual %h", $time, result_data);
      end else begin
        exp_o = expected_nodes.pop_front();
        n_results++;
        check_field("eq_rest", exp_o.eq_rest, result_data.eq_rest);
        check_field("eq_east", exp_o.eq_east, result_data.eq_east);
        check_field("eq_north", exp_o.eq_north, result_data.eq_north);
        check_field("eq_west", exp_o.eq_west, result_data.eq_west);
        check_field("eq_south", exp_o.eq_south, result_data.eq_south);
        check_field("eq_northeast", exp_o.eq_northeast, result_data.eq_northeast);
        check_field("eq_northwest", exp_o.eq_northwest, result_data.eq_northwest);
        check_field("eq_southwest", exp_o.eq_southwest, result_data.eq_southwest);
        check_field("eq_southeast", exp_o.eq_southeast, result_data.eq_southeast);
        check_field("density", exp_o.density, result_data.density);
        check_field("vel_x", exp_o.vel_x, result_data.vel_x);
        check_field("vel_y", exp_o.vel_y, result_data.vel_y);
      end
    end
  end

  // Send one node; hold valid and payload until the transaction is taken.
  // Valid stays high across back-to-back nodes so it is never dropped and
  // raised in the same step.
  task automatic send_node(input lbmc_in_t n);
    if (!quiet_mode && $urandom_range(0, 4) == 0) begin
      node_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    node_valid <= 1'b1;
    node_data  <= n;
    @(posedge clk);
    while (node_stall) @(posedge clk);
    expected_nodes.push_back(collide(n));
    n_nodes++;
  endtask

  task automatic go_idle();
    node_valid <= 1'b0;
  endtask

  function automatic val_t rand_val();
    case ($urandom_range(0, 5))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return val_t'($urandom_range(0, 8) - 4);
      default: return val_t'($urandom());
    endcase
  endfunction

  // Physical node: small populations near rest, not always positive, small push.
  function automatic lbmc_in_t phys_node();
    lbmc_in_t n;
    int base;
    base = $urandom_range(1, 1 << FB);
    n.f_rest = val_t'(base * 4 / 9 + $urandom_range(0, 2000) - 1000);
    n.f_east = val_t'(base / 9 + $urandom_range(0, 2000) - 1000);
    n.f_north = val_t'(base / 9 + $urandom_range(0, 2000) - 1000);
    n.f_west = val_t'(base / 9 + $urandom_range(0, 2000) - 1000);
    n.f_south = val_t'(base / 9 + $urandom_range(0, 2000) - 1000);
    n.f_northeast = val_t'(base / 36 + $urandom_range(0, 500) - 250);
    n.f_northwest = val_t'(base / 36 + $urandom_range(0, 500) - 250);
    n.f_southwest = val_t'(base / 36 + $urandom_range(0, 500) - 250);
    n.f_southeast = val_t'(base / 36 + $urandom_range(0, 500) - 250);
    n.push_vel_x = val_t'($urandom_range(0, 2000) - 1000);
    n.push_vel_y = val_t'($urandom_range(0, 2000) - 1000);
    return n;
  endfunction

  function automatic lbmc_in_t wild_node();
    lbmc_in_t n;
    n = {rand_val(), rand_val(), rand_val(), rand_val(), rand_val(), rand_val(),
         rand_val(), rand_val(), rand_val(), rand_val(), rand_val()};
    return n;
  endfunction

  function automatic lbmc_in_t fill_node(input val_t v, input val_t px, input val_t py);
    lbmc_in_t n;
    n = {v, v, v, v, v, v, v, v, v, px, py};
    return n;
  endfunction

  // Directed extremes: all-max, all-min, zero and negative density,
  // saturated sums, single direction momentum, large push.
  task automatic test_extremes();
    lbmc_in_t n;
    send_node(fill_node(VAL_MAX, VAL_MAX, VAL_MAX));
    send_node(fill_node(VAL_MIN, VAL_MIN, VAL_MIN));
    send_node(fill_node('0, '0, '0));
    send_node(fill_node('0, VAL_MAX, VAL_MIN));
    send_node(fill_node(val_t'(-1), 24'sd100, -24'sd100));
    send_node(fill_node(val_t'(1 << FB) / 9, '0, '0));
    send_node(fill_node(24'sd1, 24'sd1, 24'sd1));
    for (int k = 0; k < 9; k++) begin
      n = fill_node('0, '0, '0);
      n[24 * (10 - k) +: 24] = val_t'(1 << FB);
      send_node(n);
      n[24 * (10 - k) +: 24] = VAL_MIN;
      send_node(n);
    end
    n = fill_node('0, '0, '0);
    n.f_rest = 24'sd1;
    n.f_east = VAL_MAX;
    n.f_west = VAL_MIN;
    send_node(n);
    n = fill_node(24'h555555, 24'haaaaaa, 24'h555555);
    send_node(n);
    send_node(~n);
    go_idle();
  endtask

  // Random mix: mostly physical nodes, some wide-range noise.
  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 6) send_node(phys_node());
      else send_node(wild_node());
    end
    go_idle();
  endtask

  // Hold the sender until every outstanding result has drained.
  task automatic wait_drained();
    while (expected_nodes.size() != 0) @(posedge clk);
  endtask

  initial begin
    n_fail = 0;
    n_nodes = 0;
    n_results = 0;
    quiet_mode = 1'b0;
    rst = 1'b1;
    node_valid = 1'b0;
    node_data = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    wait_drained();
    test_random(900);
    wait_drained();
    quiet_mode = 1'b1;
    test_random(280);
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk);
    $display("Ran %0d nodes (extremes, physical and wide-range), %0d results checked.",
             n_nodes, n_results);
    if (n_fail == 0 && expected_nodes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
src/lbmc_pkg.sv
src/lbmc_front.sv
src/lbmc_queue.sv
src/lbmc_vel_div.sv
src/lbmc_equil.sv
src/lbm_d2q9_node_collision.sv
tb/sv/tb_top.sv
